@@ sv/uvdm_pkg.sv @@
// Package for the UTF-8 validator with delete mask.
// Holds the byte range constants and the per-byte result type.
// No dependencies.
`timescale 1ns / 1ps

package uvdm_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HIST_W = 6;

    localparam logic [BYTE_W-1:0] LEAD_ANY_LO = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hF4;
    localparam logic [BYTE_W-1:0] CONT_LO     = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_HI     = 8'hBF;
    localparam logic [BYTE_W-1:0] CONT_MID_LO = 8'h90;
    localparam logic [BYTE_W-1:0] CONT_LOW_HI = 8'h8F;
    localparam logic [BYTE_W-1:0] CONT_MID_HI = 8'h9F;
    localparam logic [BYTE_W-1:0] CONT_TOP_LO = 8'hA0;
    localparam logic [BYTE_W-1:0] SURR_LEAD   = 8'hED;

    // History bit positions
    localparam int unsigned H_L2_1 = 0;
    localparam int unsigned H_L3_1 = 1;
    localparam int unsigned H_L3_2 = 2;
    localparam int unsigned H_L4_1 = 3;
    localparam int unsigned H_L4_2 = 4;
    localparam int unsigned H_L4_3 = 5;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [HIST_W-1:0] t_hist;

    typedef struct packed {
        logic invalid_flag;
        logic delete_flag;
    } t_result;

endpackage

@@ sv/uvdm_classify.sv @@
// Per-byte classifier: delete and error decision plus the next lead history.
// Purely combinational; the caller owns the state registers.
// Depends on uvdm_pkg.
`timescale 1ns / 1ps

module uvdm_classify (
    input  uvdm_pkg::t_byte   i_byte,
    input  uvdm_pkg::t_byte   i_prev,
    input  uvdm_pkg::t_hist   i_hist,
    output uvdm_pkg::t_result o_result,
    output uvdm_pkg::t_hist   o_hist
);
    import uvdm_pkg::*;

    logic lead_any, lead2, lead3, lead4, cont;
    logic expect_cont, bad_lead, bad_second;

    always_comb begin
        lead_any = (i_byte >= LEAD_ANY_LO);
        lead2    = (i_byte >= LEAD2_LO) && (i_byte <= LEAD2_HI);
        lead3    = (i_byte >= LEAD3_LO) && (i_byte <= LEAD3_HI);
        lead4    = (i_byte >= LEAD4_LO) && (i_byte <= LEAD4_HI);
        cont     = (i_byte >= CONT_LO) && (i_byte <= CONT_HI);

        expect_cont = |i_hist;
        bad_lead    = lead_any && !(lead2 || lead3 || lead4);

        // Overlong, surrogate and out-of-range (above U+10FFFF) forms show up only in the second byte.
        bad_second =
            ((i_prev == LEAD3_LO)  && (i_byte >= CONT_LO) && (i_byte <= CONT_MID_HI)) ||
            ((i_prev == SURR_LEAD) && (i_byte >= CONT_TOP_LO) && (i_byte <= CONT_HI)) ||
            ((i_prev == LEAD4_LO)  && (i_byte >= CONT_LO) && (i_byte <= CONT_LOW_HI)) ||
            ((i_prev == LEAD4_HI)  && (i_byte >= CONT_MID_LO) && (i_byte <= CONT_HI));

        o_result.delete_flag  = lead_any || i_hist[H_L3_1] || i_hist[H_L4_1]
                                || i_hist[H_L4_2];
        o_result.invalid_flag = bad_lead || (expect_cont != cont) || bad_second;

        o_hist          = '0;
        o_hist[H_L2_1]  = lead2;
        o_hist[H_L3_1]  = lead3;
        o_hist[H_L3_2]  = i_hist[H_L3_1];
        o_hist[H_L4_1]  = lead4;
        o_hist[H_L4_2]  = i_hist[H_L4_1];
        o_hist[H_L4_3]  = i_hist[H_L4_2];
    end

endmodule

@@ sv/utf8_validate_delete_mask.sv @@
// UTF-8 validator producing a delete mask and an error mask, one word per byte.
// Top level: input register, classifier, result register. Depends on uvdm_pkg
// and uvdm_classify.
`timescale 1ns / 1ps

// Each input word carries one byte of a UTF-8 stream; each output word carries
// that byte's delete bit (tdata[0]) and error bit (tdata[1]), in order, one
// for one. The block takes a byte every cycle while the output is not held
// off. A byte is latched in the input register when it is accepted. It is
// then classified against the previous byte and a six-bit lead history, and
// its result is written to the output register once that register is free or
// draining; the output word is offered from there. Throughput is one word per
// cycle with no bubbles while the output is not held off. When the output is
// held off, the two registers fill and the input ready drops until the output
// word is taken. A sequence cut short when the stream stops is not flagged.
module utf8_validate_delete_mask (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] delete_flag, [1] invalid_flag, [7:2] zero
);
    import uvdm_pkg::*;

    logic    r_in_valid, n_in_valid;
    t_byte   r_in_data;
    logic    r_out_valid, n_out_valid;
    t_result r_out;
    t_byte   r_prev;
    t_hist   r_hist;

    t_result w_result;
    t_hist   w_hist;
    logic    w_adv;
    logic    w_acc;

    uvdm_classify u_classify (
        .i_byte   (r_in_data),
        .i_prev   (r_prev),
        .i_hist   (r_hist),
        .o_result (w_result),
        .o_hist   (w_hist)
    );

    // The input stage moves on whenever the result register is free or draining.
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_in_valid  = w_acc ? 1'b1 : (w_adv ? 1'b0 : r_in_valid);
        n_out_valid = w_adv ? 1'b1 : ((r_out_valid && i_m_tready) ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_hist      <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_adv) begin
                r_prev <= r_in_data;
                r_hist <= w_hist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in_data <= i_s_tdata;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out.invalid_flag, r_out.delete_flag};

    // Lead bytes of different lengths exclude each other in the newest history slot.
    a_hist_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_hist[H_L2_1], r_hist[H_L3_1], r_hist[H_L4_1]}))
        else $error("lead history holds two lead kinds at once");

    // Any byte from C0 up must come out marked for deletion.
    a_lead_deleted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in_data >= LEAD_ANY_LO)) |=> r_out.delete_flag)
        else $error("lead byte not marked for deletion");

    // A four-byte lead two steps back must age into the three-steps-back slot.
    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_hist[H_L4_2]) |=> r_hist[H_L4_3])
        else $error("lead history failed to shift");

    // A held byte in the input register is not overwritten.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_data)))
        else $error("stalled input byte lost");

endmodule
